[design/serial_frame_relay_pwm_controller_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the serial frame relay PWM controller
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_RELAY_PWM_CONTROLLER_UNIT_MACROS_SVH
`define SERIAL_FRAME_RELAY_PWM_CONTROLLER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define SFR_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define SFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFR_ASSERT(lbl, ante, cons, msg)
`define SFR_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

[design/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and types of the serial frame relay PWM controller.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int PAYLOAD_BYTES = 8;
  localparam int PAYLOAD_IDX_W = $clog2(PAYLOAD_BYTES);
  localparam int LEFT_W        = $clog2(PAYLOAD_BYTES + 1);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_RELOAD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_LIMIT     = 1'd1;

  localparam logic [7:0]  TIMEOUT_RELOAD_RST = 8'd20;
  localparam logic [15:0] DUTY_LIMIT_RST     = 16'd10000;
  localparam logic [7:0]  ACTIVITY_RST       = 8'd255;

  localparam logic       CMD_BYTE = 1'b0;
  localparam logic       CMD_TICK = 1'b1;
  localparam logic       CAUSE_FRAME   = 1'b0;
  localparam logic       CAUSE_TIMEOUT = 1'b1;

  localparam logic [7:0]  SYNC_BYTE  = 8'h55;
  localparam logic [15:0] CHECK_SEED = 16'd211;

  localparam logic [15:0] BIT_DIR       = 16'h0001;
  localparam logic [15:0] BIT_INTERLOCK = 16'h0004;
  localparam logic [15:0] BIT_PEDAL     = 16'h0008;
  localparam logic [15:0] BIT_PANEL     = 16'h0010;
  localparam logic [15:0] BIT_LIGHT_AI  = 16'h0020;
  localparam logic [15:0] BIT_DIMENS    = 16'h0040;
  localparam logic [15:0] BIT_TURN_AI   = 16'h0100;
  localparam logic [15:0] BIT_LEFT      = 16'h0200;
  localparam logic [15:0] BIT_RIGHT     = 16'h0400;
  localparam logic [15:0] BIT_BRAKE     = 16'h0800;
  localparam logic [15:0] TIMEOUT_RELAYS = BIT_LEFT | BIT_RIGHT | BIT_TURN_AI;

  typedef enum logic {
    PK_TICK  = 1'b0,
    PK_FRAME = 1'b1
  } pkt_kind_e;

  // One work item handed from the parser to the executor
  typedef struct packed {
    pkt_kind_e   kind;
    logic        remote;
    logic        light_dim;
    logic        light_left;
    logic        light_right;
    logic        release_lock;
    logic        brake_off;
    logic        speed_nz;
    logic        speed_neg;
    logic [16:0] mag;
  } pkt_t;

endpackage

[design/sfr_if.sv]
// ----------------------------------------------------------------------------
// sfr_in_if / sfr_out_if
// Valid/ready channels for received items and for result items.
// ----------------------------------------------------------------------------
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] relay_word;
  logic [15:0] pwm_duty;
  logic        cause;

  modport source (output valid, output relay_word, output pwm_duty, output cause,
                  input ready);
  modport sink   (input valid, input relay_word, input pwm_duty, input cause,
                  output ready);
endinterface

[design/sfr_front.sv]
// ----------------------------------------------------------------------------
// sfr_front
// Frame parser: sync hunt, payload capture, running check, packet build.
// ----------------------------------------------------------------------------
`include "serial_frame_relay_pwm_controller_unit_macros.svh"

module sfr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  sfr_in_if.sink        in_i,
  input  logic          q_ready_i,
  output logic          push_o,
  output sfr_pkg::pkt_t pkt_o
);
  import sfr_pkg::*;

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CHECK   = 2'd2;

  logic [1:0]        phase_q, phase_d;
  logic [7:0]        prev_q, prev_d;
  logic [LEFT_W-1:0] bytes_left_q, bytes_left_d;
  logic [15:0]       check_q, check_d;
  logic [7:0]        payload_q [PAYLOAD_BYTES];

  logic                     acc;
  logic                     pl_we;
  logic [PAYLOAD_IDX_W-1:0] pl_idx;
  logic [LEFT_W-1:0]        left_dec;
  logic [15:0]              byte_term;
  logic [15:0]              sum;
  logic [15:0]              mixed;
  logic [15:0]              speed;
  pkt_t                     frame_pkt;
  pkt_t                     tick_pkt;

  assign in_i.ready = q_ready_i;
  assign acc        = in_i.valid && q_ready_i;

  assign byte_term = 16'(in_i.rx_byte) * CHECK_SEED;
  assign sum       = check_q + byte_term;
  assign mixed     = sum ^ {8'h00, sum[15:8]};
  assign left_dec  = bytes_left_q - LEFT_W'(1);
  assign pl_idx    = PAYLOAD_IDX_W'(PAYLOAD_BYTES - 1) - left_dec[PAYLOAD_IDX_W-1:0];

  // Decode the finished payload into a packet
  assign speed = {payload_q[1], payload_q[0]};
  always_comb begin
    frame_pkt              = '0;
    frame_pkt.kind         = PK_FRAME;
    frame_pkt.remote       = payload_q[4][0];
    frame_pkt.light_dim    = payload_q[2][0];
    frame_pkt.light_right  = payload_q[2][1];
    frame_pkt.light_left   = payload_q[2][2];
    frame_pkt.brake_off    = payload_q[6][0];
    frame_pkt.release_lock = payload_q[6][1];
    frame_pkt.speed_nz     = (speed != 16'h0000);
    frame_pkt.speed_neg    = speed[15];
    frame_pkt.mag          = speed[15] ? (17'h10000 - {1'b0, speed}) : {1'b0, speed};
    tick_pkt               = '0;
    tick_pkt.kind          = PK_TICK;
  end

  always_comb begin
    phase_d      = phase_q;
    prev_d       = prev_q;
    bytes_left_d = bytes_left_q;
    check_d      = check_q;
    pl_we        = 1'b0;
    push_o       = 1'b0;
    pkt_o        = tick_pkt;
    if (acc) begin
      if (in_i.command == CMD_TICK) begin
        push_o = 1'b1;
      end else begin
        prev_d = in_i.rx_byte;
        unique case (phase_q)
          PH_HUNT: begin
            if (in_i.rx_byte == SYNC_BYTE && prev_q == SYNC_BYTE) begin
              phase_d      = PH_PAYLOAD;
              check_d      = CHECK_SEED;
              bytes_left_d = LEFT_W'(PAYLOAD_BYTES);
            end
          end
          PH_PAYLOAD: begin
            bytes_left_d = left_dec;
            pl_we        = 1'b1;
            check_d      = mixed;
            if (left_dec == '0) begin
              phase_d = PH_CHECK;
            end
          end
          PH_CHECK: begin
            if (in_i.rx_byte == check_q[7:0]) begin
              push_o = 1'b1;
              pkt_o  = frame_pkt;
            end
            phase_d = PH_HUNT;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      prev_q       <= '0;
      bytes_left_q <= '0;
      check_q      <= '0;
    end else begin
      phase_q      <= phase_d;
      prev_q       <= prev_d;
      bytes_left_q <= bytes_left_d;
      check_q      <= check_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pl_we) begin
      payload_q[pl_idx] <= in_i.rx_byte;
    end
  end

  `SFR_ASSERT(a_left_range, phase_q == PH_PAYLOAD, (bytes_left_q != '0) && (bytes_left_q <= LEFT_W'(PAYLOAD_BYTES)), "payload count out of range")

endmodule

[design/sfr_queue.sv]
// ----------------------------------------------------------------------------
// sfr_queue
// Short packet queue between parser and executor.
// ----------------------------------------------------------------------------
`include "serial_frame_relay_pwm_controller_unit_macros.svh"

module sfr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfr_pkg::pkt_t pkt_i,
  output logic          ready_o,
  output logic          valid_o,
  output sfr_pkg::pkt_t pkt_o,
  input  logic          pop_i
);
  import sfr_pkg::*;

  pkt_t              entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign ready_o = (count_q != QCNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign pkt_o   = entry_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d    = do_push ? wr_q + QPTR_W'(1) : wr_q;
    rd_d    = do_pop ? rd_q + QPTR_W'(1) : rd_q;
    count_d = count_q + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= pkt_i;
    end
  end

  `SFR_ASSERT(a_count_range, 1'b1, count_q <= QCNT_W'(QDEPTH), "queue count overflow")

endmodule

[design/sfr_back.sv]
// ----------------------------------------------------------------------------
// sfr_back
// Executor: activity counter, relay mask, duty saturation, result register.
// ----------------------------------------------------------------------------
`include "serial_frame_relay_pwm_controller_unit_macros.svh"

module sfr_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    timeout_reload_i,
  input  logic [15:0]   duty_limit_i,
  input  logic          q_valid_i,
  input  sfr_pkg::pkt_t q_pkt_i,
  output logic          q_pop_o,
  sfr_out_if.source     out_o
);
  import sfr_pkg::*;

  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] mask_q, mask_d;
  logic        ovalid_q, ovalid_d;
  logic [15:0] relay_q, relay_d;
  logic [15:0] duty_q, duty_d;
  logic        cause_q, cause_d;
  logic [15:0] m;
  logic [15:0] sat;

  assign q_pop_o = q_valid_i && (!ovalid_q || out_o.ready);
  assign sat     = (q_pkt_i.mag > {1'b0, duty_limit_i}) ? duty_limit_i : q_pkt_i.mag[15:0];

  // Remote-mode mask update, in the order the bits are decided
  always_comb begin
    m = mask_q | BIT_PEDAL | BIT_PANEL | BIT_LIGHT_AI | BIT_TURN_AI;
    m = q_pkt_i.light_dim   ? (m | BIT_DIMENS) : (m & ~BIT_DIMENS);
    m = q_pkt_i.light_left  ? (m | BIT_LEFT)   : (m & ~BIT_LEFT);
    m = q_pkt_i.light_right ? (m | BIT_RIGHT)  : (m & ~BIT_RIGHT);
    if (q_pkt_i.speed_nz) begin
      m = m | BIT_INTERLOCK;
    end
    if (q_pkt_i.release_lock) begin
      m = m & ~BIT_INTERLOCK;
    end
    m = q_pkt_i.brake_off ? (m & ~BIT_BRAKE) : (m | BIT_BRAKE);
    m = (q_pkt_i.speed_nz && !q_pkt_i.speed_neg) ? (m | BIT_DIR) : (m & ~BIT_DIR);
  end

  always_comb begin
    cnt_d    = cnt_q;
    mask_d   = mask_q;
    ovalid_d = ovalid_q && !out_o.ready;
    relay_d  = relay_q;
    duty_d   = duty_q;
    cause_d  = cause_q;
    if (q_pop_o) begin
      unique case (q_pkt_i.kind)
        PK_TICK: begin
          if (cnt_q != '0) begin
            cnt_d = cnt_q - 8'd1;
          end else begin
            ovalid_d = 1'b1;
            relay_d  = TIMEOUT_RELAYS;
            duty_d   = '0;
            cause_d  = CAUSE_TIMEOUT;
          end
        end
        PK_FRAME: begin
          cnt_d    = timeout_reload_i;
          ovalid_d = 1'b1;
          cause_d  = CAUSE_FRAME;
          if (q_pkt_i.remote) begin
            mask_d  = m;
            relay_d = m;
            duty_d  = q_pkt_i.speed_nz ? sat : 16'h0000;
          end else begin
            mask_d  = '0;
            relay_d = '0;
            duty_d  = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= ACTIVITY_RST;
      mask_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      mask_q   <= mask_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    relay_q <= relay_d;
    duty_q  <= duty_d;
    cause_q <= cause_d;
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.relay_word = relay_q;
  assign out_o.pwm_duty   = duty_q;
  assign out_o.cause      = cause_q;

  `SFR_ASSERT(a_timeout_pattern, ovalid_q && (cause_q == CAUSE_TIMEOUT), (relay_q == TIMEOUT_RELAYS) && (duty_q == 16'h0000), "bad fallback result")
  `SFR_ASSERT(a_duty_limit, ovalid_q, duty_q <= duty_limit_i, "duty above limit")
  `SFR_ASSERT_NXT(a_tick_dec, q_pop_o && (q_pkt_i.kind == PK_TICK) && (cnt_q != '0), (cnt_q == $past(cnt_q) - 8'd1) && (mask_q == $past(mask_q)), "tick did not count down")

endmodule

[design/serial_frame_relay_pwm_controller_unit.sv]
// ----------------------------------------------------------------------------
// serial_frame_relay_pwm_controller_unit
// Serial command frame parser driving a relay pattern and a motor PWM duty.
// ----------------------------------------------------------------------------
// Each input beat is either a received serial byte or a timer tick, and the
// block takes one beat every clock cycle as long as its two-entry internal
// queue has room; with the result side taking beats freely it never stalls.
// A frame is two 0x55 sync bytes, eight little-endian payload bytes (signed
// speed, light word, system words A and B) and a check byte. The parser
// (front) folds each payload byte into a 16-bit check seeded with 211 and,
// on a matching check byte, hands a decoded packet to the executor (back);
// ticks are forwarded as packets too. The executor owns the activity counter
// and relay mask, and writes one result beat into an output register: with
// an empty queue and a free output register, a frame result passes from the
// queue entry into the output register once its check byte is accepted, and
// leaves from there. A fallback result (hazard lights, zero duty) comes for
// every tick that finds the counter at zero, by the same path. Ticks with
// a nonzero counter only count down and give no beat. Configuration writes
// (index 0: timeout reload, index 1: duty limit) take effect on the next
// clock and are meant for idle periods only.
// ----------------------------------------------------------------------------
module serial_frame_relay_pwm_controller_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sfr_in_if.sink                          in_i,
  sfr_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import sfr_pkg::*;

  // Configuration registers
  logic [7:0]  timeout_reload_q, timeout_reload_d;
  logic [15:0] duty_limit_q, duty_limit_d;

  // Front to queue, queue to back
  logic q_ready;
  logic push;
  pkt_t push_pkt;
  logic q_valid;
  pkt_t q_pkt;
  logic q_pop;

  // Decode the register index and hold everything else
  always_comb begin
    timeout_reload_d = timeout_reload_q;
    duty_limit_d     = duty_limit_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TIMEOUT_RELOAD: timeout_reload_d = cfg_data_i[7:0];
        CFG_DUTY_LIMIT:     duty_limit_d     = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_reload_q <= TIMEOUT_RELOAD_RST;
      duty_limit_q     <= DUTY_LIMIT_RST;
    end else begin
      timeout_reload_q <= timeout_reload_d;
      duty_limit_q     <= duty_limit_d;
    end
  end

  // Parse bytes, check frames, forward ticks
  sfr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .push_o    (push),
    .pkt_o     (push_pkt)
  );

  // Decouple parser from executor so either side can stall alone
  sfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pkt_i   (push_pkt),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pkt_o   (q_pkt),
    .pop_i   (q_pop)
  );

  // Apply packets to the counter and mask, register the result beat
  sfr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .timeout_reload_i (timeout_reload_q),
    .duty_limit_i     (duty_limit_q),
    .q_valid_i        (q_valid),
    .q_pkt_i          (q_pkt),
    .q_pop_o          (q_pop),
    .out_o            (out_o)
  );

endmodule

[dv/tb_serial_frame_relay_pwm_controller_unit.sv]
// ----------------------------------------------------------------------------
// tb_serial_frame_relay_pwm_controller_unit
// Self-checking bench for the serial frame relay PWM controller: a queue-fed
// driver offers byte and tick beats, a parser/executor predictor tracks sync,
// check, relay mask and activity counter, and a monitor compares each result
// beat field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_serial_frame_relay_pwm_controller_unit;
  import sfr_pkg::*;

  localparam int IDLE_PCT     = 31;   // chance per cycle that a side idles
  localparam int DRAIN_CYCLES = 12;   // covers the executor pipe and its queue
  localparam int HOLD_CYCLES  = 300;  // long receiver hold-off

  // Parser phases of the predictor
  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_BODY  = 2'd1,
    PH_CHECK = 2'd2,
    PH_SPARE = 2'd3
  } frame_phase_e;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } link_beat_t;

  typedef struct packed {
    logic [15:0] relays;
    logic [15:0] duty;
    logic        cause;
  } relay_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx  = CFG_TIMEOUT_RELOAD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sfr_in_if  in_if ();
  sfr_out_if out_if ();

  serial_frame_relay_pwm_controller_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Beats waiting to be offered, and relay results waiting to come out
  link_beat_t    link_beats[$];
  relay_result_t relay_results_due[$];

  // Predictor state, starting from the reset values
  logic [7:0]   reload_ticks   = TIMEOUT_RELOAD_RST;
  logic [15:0]  duty_ceiling   = DUTY_LIMIT_RST;
  frame_phase_e frame_phase    = PH_HUNT;
  logic [7:0]   last_byte      = 8'h00;
  int           bytes_due      = 0;
  logic [15:0]  check_acc      = '0;
  logic [7:0]   payload_store[PAYLOAD_BYTES];
  logic [15:0]  relay_state    = '0;
  logic [7:0]   activity_left  = ACTIVITY_RST;

  int fault_count  = 0;
  bit steady_flow  = 1'b0;  // both sides stop idling while set
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hold reset, then release it; keep every channel input at a known value
  initial begin
    in_if.valid   = 1'b0;
    in_if.command = CMD_BYTE;
    in_if.rx_byte = 8'h00;
    out_if.ready  = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Fold one payload byte into the running check
  function automatic logic [15:0] fold_check(logic [15:0] acc, logic [7:0] data);
    logic [15:0] sum;
    sum = acc + CHECK_SEED * {8'h00, data};
    return sum ^ {8'h00, sum[15:8]};
  endfunction

  function automatic logic [7:0] check_of(logic [63:0] body);
    logic [15:0] acc;
    acc = CHECK_SEED;
    for (int i = 0; i < PAYLOAD_BYTES; i++) acc = fold_check(acc, body[8*i +: 8]);
    return acc[7:0];
  endfunction

  function automatic logic [15:0] with_bit(logic [15:0] m, logic [15:0] b, logic on);
    return on ? (m | b) : (m & ~b);
  endfunction

  // Decode the stored payload into the new relay mask and duty
  function automatic relay_result_t apply_frame();
    relay_result_t r;
    logic [15:0]   speed, light, sys_a, sys_b;
    logic [16:0]   mag;
    speed  = {payload_store[1], payload_store[0]};
    light  = {payload_store[3], payload_store[2]};
    sys_a  = {payload_store[5], payload_store[4]};
    sys_b  = {payload_store[7], payload_store[6]};
    r.duty  = '0;
    r.cause = CAUSE_FRAME;
    activity_left = reload_ticks;
    if (!sys_a[0]) begin
      // Local mode: drop every relay and the motor
      relay_state = '0;
    end else begin
      relay_state = relay_state | BIT_PEDAL | BIT_PANEL | BIT_LIGHT_AI | BIT_TURN_AI;
      relay_state = with_bit(relay_state, BIT_DIMENS, light[0]);
      relay_state = with_bit(relay_state, BIT_LEFT, light[2]);
      relay_state = with_bit(relay_state, BIT_RIGHT, light[1]);
      // Zero speed leaves the interlock as it was
      if (speed != 16'h0000) begin
        relay_state = relay_state | BIT_INTERLOCK;
        mag = speed[15] ? (17'h10000 - {1'b0, speed}) : {1'b0, speed};
        r.duty = (mag > {1'b0, duty_ceiling}) ? duty_ceiling : mag[15:0];
      end
      if (sys_b[1]) relay_state = relay_state & ~BIT_INTERLOCK;
      relay_state = with_bit(relay_state, BIT_BRAKE, !sys_b[0]);
      relay_state = with_bit(relay_state, BIT_DIR, speed != 16'h0000 && !speed[15]);
    end
    r.relays = relay_state;
    return r;
  endfunction

  // Advance the predictor by one accepted beat; queue any result it causes
  function automatic void follow_link_beat(link_beat_t b);
    relay_result_t r;
    if (b.command == CMD_TICK) begin
      if (activity_left != 8'h00) begin
        activity_left = activity_left - 8'd1;
      end else begin
        // Hazard pattern; the stored mask stays untouched
        r.relays = TIMEOUT_RELAYS;
        r.duty   = '0;
        r.cause  = CAUSE_TIMEOUT;
        relay_results_due.push_back(r);
      end
    end else begin
      case (frame_phase)
        PH_HUNT: begin
          if (b.rx_byte == SYNC_BYTE && last_byte == SYNC_BYTE) begin
            frame_phase = PH_BODY;
            check_acc   = CHECK_SEED;
            bytes_due   = PAYLOAD_BYTES;
          end
        end
        PH_BODY: begin
          bytes_due = bytes_due - 1;
          if (bytes_due == 0) frame_phase = PH_CHECK;
          payload_store[PAYLOAD_BYTES - 1 - bytes_due] = b.rx_byte;
          check_acc = fold_check(check_acc, b.rx_byte);
        end
        PH_CHECK: begin
          if (b.rx_byte == check_acc[7:0]) relay_results_due.push_back(apply_frame());
          frame_phase = PH_HUNT;
        end
        default: begin
        end
      endcase
      // The check byte counts as the previous byte for the next sync
      last_byte = b.rx_byte;
    end
  endfunction

  // Driver: predict on each accepted beat, then offer the next one or idle
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) follow_link_beat('{in_if.command, in_if.rx_byte});
      if (!in_if.valid || in_if.ready) begin
        if (link_beats.size() != 0 && (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
          in_if.valid   <= 1'b1;
          in_if.command <= link_beats[0].command;
          in_if.rx_byte <= link_beats[0].rx_byte;
          void'(link_beats.pop_front());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Compare one result beat with the oldest prediction
  function automatic void check_relay_result();
    relay_result_t want;
    if (relay_results_due.size() == 0) begin
      $error("relay_word: no result due, got %h (pwm_duty %h, cause %b)",
             out_if.relay_word, out_if.pwm_duty, out_if.cause);
      fault_count++;
    end else begin
      want = relay_results_due.pop_front();
      if (out_if.relay_word !== want.relays) begin
        $error("relay_word: expected %h, got %h", want.relays, out_if.relay_word);
        fault_count++;
      end
      if (out_if.pwm_duty !== want.duty) begin
        $error("pwm_duty: expected %0d, got %0d", want.duty, out_if.pwm_duty);
        fault_count++;
      end
      if (out_if.cause !== want.cause) begin
        $error("cause: expected %b, got %b", want.cause, out_if.cause);
        fault_count++;
      end
    end
  endfunction

  // Monitor: check accepted result beats, drive ready with random stalls and
  // serve long hold-offs on request, counting them down here
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_relay_result();
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
        holds_served = holds_served + 1;
        hold_left    = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic queue_byte(input logic [7:0] data);
    link_beat_t b;
    b.command = CMD_BYTE;
    b.rx_byte = data;
    link_beats.push_back(b);
  endtask

  task automatic queue_tick();
    link_beat_t b;
    b.command = CMD_TICK;
    b.rx_byte = 8'($urandom);  // ignored by the block, toggles the field bits
    link_beats.push_back(b);
  endtask

  // Sync pair (unless with_sync is clear), eight payload bytes, then the check byte (spoiled if not good)
  task automatic queue_frame(input logic [63:0] body, input bit good,
                             input bit with_sync = 1'b1);
    logic [7:0] chk;
    chk = check_of(body);
    if (!good) chk = chk ^ 8'($urandom_range(1, 255));
    if (with_sync) begin
      queue_byte(SYNC_BYTE);
      queue_byte(SYNC_BYTE);
    end
    for (int i = 0; i < PAYLOAD_BYTES; i++) queue_byte(body[8*i +: 8]);
    queue_byte(chk);
  endtask

  // Payload {sys_b, sys_a, light, speed}, speed biased toward its extremes and small magnitudes
  function automatic logic [63:0] random_frame_body();
    logic [15:0] speed, sys_a;
    case ($urandom_range(7))
      0:       speed = 16'h0000;
      1:       speed = 16'h8000;
      2:       speed = 16'h7FFF;
      3:       speed = 16'hFFFF;
      4:       speed = 16'($urandom_range(300));
      5:       speed = 16'h0000 - 16'($urandom_range(1, 300));
      default: speed = 16'($urandom);
    endcase
    sys_a    = 16'($urandom);
    sys_a[0] = ($urandom_range(99) < 80);
    return {16'($urandom), sys_a, 16'($urandom), speed};
  endfunction

  // Mostly well-formed frames with random content, plus ticks, noise and
  // broken frames
  task automatic queue_random_traffic(input int beats);
    int          goal, k, n;
    logic [63:0] body;
    goal = link_beats.size() + beats;
    while (link_beats.size() < goal) begin
      k = $urandom_range(99);
      if (k < 58) begin
        queue_frame(random_frame_body(), $urandom_range(99) < 88);
      end else if (k < 74) begin
        repeat ($urandom_range(1, 6)) queue_tick();
      end else if (k < 83) begin
        repeat ($urandom_range(1, 4))
          queue_byte(($urandom_range(99) < 30) ? SYNC_BYTE : 8'($urandom));
      end else if (k < 90) begin
        // Truncated frame: the beats that follow get swallowed as payload
        n = $urandom_range(7);
        queue_byte(SYNC_BYTE);
        queue_byte(SYNC_BYTE);
        repeat (n) queue_byte(8'($urandom));
      end else if (k < 95) begin
        // Good frame with ticks landing in the middle of it
        body = random_frame_body();
        queue_byte(SYNC_BYTE);
        queue_byte(SYNC_BYTE);
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
          if ($urandom_range(3) == 0) queue_tick();
          queue_byte(body[8*i +: 8]);
        end
        queue_byte(check_of(body));
      end else begin
        // Three sync bytes in a row: the third lands in the payload
        queue_byte(SYNC_BYTE);
        queue_frame(random_frame_body(), 1'b1);
      end
    end
  endtask

  // Write one register; the block is idle whenever this is called
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    if (idx == CFG_TIMEOUT_RELOAD) reload_ticks = value[7:0];
    else duty_ceiling = value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Hold until every beat went in and every result came out, then let ticks
  // that cause no result clear the executor
  task automatic wait_quiet();
    do @(negedge clk_i);
    while (link_beats.size() != 0 || in_if.valid || relay_results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] chain;
    wait (rst_ni);
    @(negedge clk_i);

    // Directed beats at the reset settings
    queue_tick();
    queue_tick();
    queue_frame({16'h0000, 16'h0001, 16'h0007, 16'h0001}, 1'b1);  // slow forward, brake on
    queue_frame({16'h0003, 16'hFFFF, 16'h0000, 16'h8000}, 1'b1);  // most negative, lock released
    queue_frame({16'h0002, 16'h0001, 16'hFFFF, 16'h7FFF}, 1'b1);  // most positive, saturates
    queue_frame({16'h0001, 16'h0001, 16'h0002, 16'h0000}, 1'b1);  // zero speed keeps interlock
    queue_frame({16'h0000, 16'h0001, 16'h0004, 16'hFFFF}, 1'b1);  // minus one, reverse
    queue_frame({16'hFFFF, 16'hFFFE, 16'hFFFF, 16'h1234}, 1'b1);  // remote off clears all
    queue_frame(random_frame_body(), 1'b0);                       // check mismatch, dropped
    queue_frame({64{1'b1}}, 1'b1);                                // all-ones payload
    queue_frame(64'h0, 1'b1);                                     // all-zero payload, local
    queue_byte(SYNC_BYTE);                                        // lone sync, no frame
    queue_byte(8'h00);
    // A check byte of 0x55 followed by one more 0x55 opens the next frame
    do chain = random_frame_body(); while (check_of(chain) != SYNC_BYTE);
    queue_frame(chain, 1'b1);
    queue_byte(SYNC_BYTE);
    queue_frame(random_frame_body(), 1'b1, 1'b0);
    wait_quiet();

    // Timeout reload of one, zero duty ceiling: fallback on the second tick
    set_register(CFG_TIMEOUT_RELOAD, 16'd1);
    set_register(CFG_DUTY_LIMIT, 16'd0);
    @(negedge clk_i);
    queue_frame({16'h0000, 16'h0001, 16'h0006, 16'h8000}, 1'b1);
    repeat (4) queue_tick();
    queue_random_traffic(250);
    wait_quiet();

    // Widest settings, no idling on either side
    set_register(CFG_TIMEOUT_RELOAD, 16'd255);
    set_register(CFG_DUTY_LIMIT, 16'hFFFF);
    @(negedge clk_i);
    steady_flow = 1'b1;
    queue_frame({16'h0000, 16'h0001, 16'h0000, 16'h8000}, 1'b1);  // duty 32768
    queue_frame({16'h0000, 16'h0001, 16'h0000, 16'h7FFF}, 1'b1);
    queue_random_traffic(300);
    wait_quiet();
    steady_flow = 1'b0;

    // Long receiver hold-off while beats keep coming, so the block backs up
    set_register(CFG_TIMEOUT_RELOAD, 16'd2);
    set_register(CFG_DUTY_LIMIT, 16'($urandom));
    @(negedge clk_i);
    holds_asked = holds_asked + 1;
    queue_random_traffic(350);
    wait_quiet();

    set_register(CFG_TIMEOUT_RELOAD, 16'($urandom_range(1, 255)));
    set_register(CFG_DUTY_LIMIT, 16'($urandom));
    @(negedge clk_i);
    queue_random_traffic(400);
    wait_quiet();

    set_register(CFG_TIMEOUT_RELOAD, 16'($urandom_range(1, 8)));
    set_register(CFG_DUTY_LIMIT, 16'($urandom_range(0, 40000)));
    @(negedge clk_i);
    queue_random_traffic(400);
    wait_quiet();

    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Guard against a hang: a correct run needs well under a tenth of this
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule

[serial_frame_relay_pwm_controller_unit.f]
+incdir+design
design/sfr_pkg.sv
design/sfr_if.sv
design/sfr_front.sv
design/sfr_queue.sv
design/sfr_back.sv
design/serial_frame_relay_pwm_controller_unit.sv
dv/tb_serial_frame_relay_pwm_controller_unit.sv
